>>> hw/rtl/msw_pkg.sv
// Shared types and constants for the mean shift window tracker.
// Field widths, register indexes, unit status and controller states.
// No dependencies.
package msw_pkg;

  localparam int MAX_COLS_DEF   = 512;
  localparam int MAX_ROWS_DEF   = 512;
  localparam int MAX_WINDOW_DEF = 128;

  localparam int PIXEL_W     = 8;
  localparam int START_W     = 9;
  localparam int ROI_W       = 9;
  localparam int CTR_W       = 10;
  localparam int ROUNDS_W    = 8;
  localparam int FRAME_REG_W = 10;
  localparam int WIN_REG_W   = 8;
  localparam int ITER_REG_W  = 8;
  localparam int EPS_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int S_TDATA_W   = 32;
  localparam int S_TUSER_W   = 1;
  localparam int M_TDATA_W   = 72;
  localparam int M_TUSER_W   = 2;

  localparam logic [FRAME_REG_W-1:0] FRAME_WIDTH_RST  = 10'd320;
  localparam logic [FRAME_REG_W-1:0] FRAME_HEIGHT_RST = 10'd240;
  localparam logic [WIN_REG_W-1:0]   WINDOW_WIDTH_RST = 8'd32;
  localparam logic [WIN_REG_W-1:0]   WINDOW_HEIGHT_RST = 8'd32;
  localparam logic [ITER_REG_W-1:0]  MAX_ITER_RST     = 8'd10;
  localparam logic [EPS_W-1:0]       EPSILON_RST      = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_WINDOW_WIDTH,
    REG_WINDOW_HEIGHT,
    REG_MAX_ITERATIONS,
    REG_EPSILON
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROUND_INIT,
    S_SWEEP,
    S_DRAIN,
    S_OFFSET_X,
    S_OFFSET_Y,
    S_AX_GO,
    S_AX_WAIT,
    S_AY_GO,
    S_AY_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_EP_GO,
    S_EP_WAIT,
    S_COMPARE,
    S_DX_GO,
    S_DX_WAIT,
    S_DY_GO,
    S_DY_WAIT,
    S_MOVE,
    S_FINISH
  } state_t;

endpackage

>>> hw/rtl/mean_shift_window_tracker.sv
// Mean shift window tracker: frame store, window sweep, controller, result register.
// Depends on msw_pkg, msw_frame_mem, msw_mul_serial and msw_div_serial.
//
// Pixel beats (tuser 0) are written into the frame store in raster order at one
// per cycle. A start beat (tuser 1) runs the search and blocks input until it ends;
// its one result beat waits in an output register while new pixels flow in. Each
// round sweeps the window through the single read port of the frame store, then
// runs four serial multiplies for the convergence test and, unless it converges,
// two serial divides for the window move. An empty window ends the search after
// the sweep, and the search also ends when max_iterations rounds have run.
module mean_shift_window_tracker #(
  parameter int MAX_COLS   = msw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = msw_pkg::MAX_ROWS_DEF,
  parameter int MAX_WINDOW = msw_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pixel[7:0], start_x[16:8], start_y[25:17], zero fill
  input  logic [msw_pkg::S_TDATA_W-1:0]   s_tdata,
  // kind[0]
  input  logic [msw_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // roi_x[8:0], roi_y[17:9], window_center_x[27:18], window_center_y[37:28],
  // centroid_x[47:38], centroid_y[57:48], rounds_used[65:58], zero fill
  output logic [msw_pkg::M_TDATA_W-1:0]   m_tdata,
  // converged[0], empty_window[1]
  output logic [msw_pkg::M_TUSER_W-1:0]   m_tuser,
  input  logic                            cfg_we,
  input  logic [msw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PIXEL_W = msw_pkg::PIXEL_W;
  localparam int CTR_W   = msw_pkg::CTR_W;
  localparam int ROI_W   = msw_pkg::ROI_W;
  localparam int EPS_W   = msw_pkg::EPS_W;
  localparam int COLS_W  = $clog2(MAX_COLS + 1);
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int X_W     = $clog2(MAX_COLS);
  localparam int Y_W     = $clog2(MAX_ROWS);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FS_W    = COLS_W + ROWS_W;
  localparam int MASS_W  = PIXEL_W + 2 * WIN_W;
  localparam int MOM_W   = MASS_W + WIN_W;
  localparam int AX_W    = MOM_W + 1;
  localparam int SQ_W    = 2 * AX_W + 1;
  localparam int MSQ_W   = 2 * MASS_W;
  localparam int RHS_W   = MSQ_W + EPS_W;
  localparam int MA_W    = (AX_W > MSQ_W) ? AX_W : MSQ_W;
  localparam int MB0_W   = (AX_W > MASS_W) ? AX_W : MASS_W;
  localparam int MB_W    = (MB0_W > EPS_W) ? MB0_W : EPS_W;
  localparam int P_W     = MA_W + MB_W;
  localparam int XW_MAX  = (X_W > WIN_W) ? X_W : WIN_W;
  localparam int V_W     = ((XW_MAX > COLS_W) ? XW_MAX : COLS_W) + 2;
  localparam int S_W     = ((XW_MAX > CTR_W) ? XW_MAX : CTR_W) + 1;

  // configuration registers
  logic [msw_pkg::FRAME_REG_W-1:0] frame_width;
  logic [msw_pkg::FRAME_REG_W-1:0] frame_height;
  logic [msw_pkg::WIN_REG_W-1:0]   window_width;
  logic [msw_pkg::WIN_REG_W-1:0]   window_height;
  logic [msw_pkg::ITER_REG_W-1:0]  max_iterations;
  logic [EPS_W-1:0]                epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= msw_pkg::FRAME_WIDTH_RST;
      frame_height   <= msw_pkg::FRAME_HEIGHT_RST;
      window_width   <= msw_pkg::WINDOW_WIDTH_RST;
      window_height  <= msw_pkg::WINDOW_HEIGHT_RST;
      max_iterations <= msw_pkg::MAX_ITER_RST;
      epsilon        <= msw_pkg::EPSILON_RST;
    end else if (cfg_we) begin
      case (msw_pkg::cfg_reg_t'(cfg_index))
        msw_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data[msw_pkg::FRAME_REG_W-1:0];
        msw_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data[msw_pkg::FRAME_REG_W-1:0];
        msw_pkg::REG_WINDOW_WIDTH:   window_width   <= cfg_data[msw_pkg::WIN_REG_W-1:0];
        msw_pkg::REG_WINDOW_HEIGHT:  window_height  <= cfg_data[msw_pkg::WIN_REG_W-1:0];
        msw_pkg::REG_MAX_ITERATIONS: max_iterations <= cfg_data[msw_pkg::ITER_REG_W-1:0];
        msw_pkg::REG_EPSILON:        epsilon        <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [COLS_W-1:0] fw;
  logic [ROWS_W-1:0] fh;
  logic [WIN_W-1:0]  cap_x, cap_y, ww, wh, cx, cy;
  logic [X_W-1:0]    ux;
  logic [Y_W-1:0]    uy;
  logic [FS_W-1:0]   frame_size;

  always_comb begin
    if (frame_width < 2) fw = COLS_W'(2);
    else if (frame_width > MAX_COLS) fw = COLS_W'(MAX_COLS);
    else fw = COLS_W'(frame_width);
    if (frame_height < 2) fh = ROWS_W'(2);
    else if (frame_height > MAX_ROWS) fh = ROWS_W'(MAX_ROWS);
    else fh = ROWS_W'(frame_height);
    cap_x = (fw < MAX_WINDOW) ? WIN_W'(fw) : WIN_W'(MAX_WINDOW);
    cap_y = (fh < MAX_WINDOW) ? WIN_W'(fh) : WIN_W'(MAX_WINDOW);
    if (window_width == '0) ww = WIN_W'(1);
    else if (window_width > cap_x) ww = cap_x;
    else ww = WIN_W'(window_width);
    if (window_height == '0) wh = WIN_W'(1);
    else if (window_height > cap_y) wh = cap_y;
    else wh = WIN_W'(window_height);
    cx = ww >> 1;
    cy = wh >> 1;
    ux = X_W'(V_W'(fw) - V_W'(ww));
    uy = Y_W'(V_W'(fh) - V_W'(wh));
    frame_size = FS_W'(fw) * FS_W'(fh);
  end

  // input fields
  logic                          in_kind;
  logic [PIXEL_W-1:0]            in_pixel;
  logic [msw_pkg::START_W-1:0]   in_start_x, in_start_y;

  assign in_kind    = s_tuser[0];
  assign in_pixel   = s_tdata[PIXEL_W-1:0];
  assign in_start_x = s_tdata[PIXEL_W +: msw_pkg::START_W];
  assign in_start_y = s_tdata[PIXEL_W + msw_pkg::START_W +: msw_pkg::START_W];

  msw_pkg::state_t state, state_next;

  // frame store write side
  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] wp_eff;
  logic [ADDR_W:0]   wp_inc;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_raddr;
  logic [PIXEL_W-1:0] mem_rdata;

  always_comb begin
    wp_eff = (FS_W'(wp) >= frame_size) ? '0 : wp;
    wp_inc = {1'b0, wp_eff} + 1'b1;
    mem_we = (state == msw_pkg::S_IDLE) && s_tvalid && !in_kind;
  end

  // search registers
  logic [X_W-1:0]    rx;
  logic [Y_W-1:0]    ry;
  logic [ADDR_W-1:0] row_base;
  logic [WIN_W-1:0]  sx, sy, px, py;
  logic              rd_valid;
  logic [MASS_W-1:0] m00;
  logic [MOM_W-1:0]  m10, m01;
  logic [AX_W-1:0]   ax, ay;
  logic [SQ_W-1:0]   sq_sum;
  logic [MSQ_W-1:0]  msq;
  logic [RHS_W-1:0]  rhs;
  logic [WIN_W-1:0]  gx, gy;
  logic [msw_pkg::ROUNDS_W-1:0] rounds;
  logic              conv, empty;
  logic [CTR_W-1:0]  rec_center_x, rec_center_y, rec_centroid_x, rec_centroid_y;

  assign mem_raddr = ADDR_W'(row_base + ADDR_W'(sx));

  msw_frame_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W),
    .DATA_W(PIXEL_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wp_eff),
    .wdata(in_pixel),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // arithmetic units
  logic                  mul_start;
  logic [MA_W-1:0]       mul_a;
  logic [MB_W-1:0]       mul_b;
  logic [P_W-1:0]        mul_p;
  msw_pkg::unit_status_t mul_status;
  logic                  div_start;
  logic [MOM_W-1:0]      div_num;
  logic [MOM_W-1:0]      div_quo;
  logic [MASS_W-1:0]     div_rem;
  msw_pkg::unit_status_t div_status;

  msw_mul_serial #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .product(mul_p),
    .status (mul_status)
  );

  msw_div_serial #(.N_W(MOM_W), .D_W(MASS_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (m00),
    .quo   (div_quo),
    .rem   (div_rem),
    .status(div_status)
  );

  // derived values
  logic               sweep_last;
  logic [AX_W-1:0]    two_m10, two_m01, ww_m00, wh_m00;
  logic               round_up;
  logic [WIN_W-1:0]   g_round;
  logic               conv_hit;
  logic signed [V_W-1:0] vx, vy, vx_lo, vy_lo;
  logic [X_W-1:0]     rx_move, rx_start;
  logic [Y_W-1:0]     ry_move, ry_start;

  always_comb begin
    sweep_last = (sx == ww - 1'b1) && (sy == wh - 1'b1);
    two_m10    = {m10, 1'b0};
    two_m01    = {m01, 1'b0};
    ww_m00     = AX_W'(ww) * AX_W'(m00);
    wh_m00     = AX_W'(wh) * AX_W'(m00);
    round_up   = ({div_rem, 1'b0} > {1'b0, m00}) ||
                 (({div_rem, 1'b0} == {1'b0, m00}) && div_quo[0]);
    g_round    = WIN_W'(div_quo + MOM_W'(round_up));
    conv_hit   = {sq_sum, 6'b0} < rhs;
    vx = $signed(V_W'(rx) + V_W'(gx) - V_W'(cx));
    vy = $signed(V_W'(ry) + V_W'(gy) - V_W'(cy));
    vx_lo = (vx < $signed(V_W'(1))) ? $signed(V_W'(1)) : vx;
    vy_lo = (vy < $signed(V_W'(1))) ? $signed(V_W'(1)) : vy;
    rx_move = (vx_lo > $signed(V_W'(ux))) ? ux : X_W'(vx_lo);
    ry_move = (vy_lo > $signed(V_W'(uy))) ? uy : Y_W'(vy_lo);
    rx_start = (in_start_x > ux) ? ux : X_W'(in_start_x);
    ry_start = (in_start_y > uy) ? uy : Y_W'(in_start_y);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      msw_pkg::S_IDLE:       if (s_tvalid && in_kind) state_next = msw_pkg::S_ROUND_INIT;
      msw_pkg::S_ROUND_INIT: state_next = (rounds < max_iterations) ? msw_pkg::S_SWEEP
                                                                    : msw_pkg::S_FINISH;
      msw_pkg::S_SWEEP:      if (sweep_last) state_next = msw_pkg::S_DRAIN;
      msw_pkg::S_DRAIN:      state_next = msw_pkg::S_OFFSET_X;
      msw_pkg::S_OFFSET_X:   state_next = (m00 == '0) ? msw_pkg::S_FINISH : msw_pkg::S_OFFSET_Y;
      msw_pkg::S_OFFSET_Y:   state_next = msw_pkg::S_AX_GO;
      msw_pkg::S_AX_GO:      state_next = msw_pkg::S_AX_WAIT;
      msw_pkg::S_AX_WAIT:    if (mul_status.done) state_next = msw_pkg::S_AY_GO;
      msw_pkg::S_AY_GO:      state_next = msw_pkg::S_AY_WAIT;
      msw_pkg::S_AY_WAIT:    if (mul_status.done) state_next = msw_pkg::S_SQ_GO;
      msw_pkg::S_SQ_GO:      state_next = msw_pkg::S_SQ_WAIT;
      msw_pkg::S_SQ_WAIT:    if (mul_status.done) state_next = msw_pkg::S_EP_GO;
      msw_pkg::S_EP_GO:      state_next = msw_pkg::S_EP_WAIT;
      msw_pkg::S_EP_WAIT:    if (mul_status.done) state_next = msw_pkg::S_COMPARE;
      msw_pkg::S_COMPARE:    state_next = conv_hit ? msw_pkg::S_FINISH : msw_pkg::S_DX_GO;
      msw_pkg::S_DX_GO:      state_next = msw_pkg::S_DX_WAIT;
      msw_pkg::S_DX_WAIT:    if (div_status.done) state_next = msw_pkg::S_DY_GO;
      msw_pkg::S_DY_GO:      state_next = msw_pkg::S_DY_WAIT;
      msw_pkg::S_DY_WAIT:    if (div_status.done) state_next = msw_pkg::S_MOVE;
      msw_pkg::S_MOVE:       state_next = msw_pkg::S_ROUND_INIT;
      msw_pkg::S_FINISH:     if (!m_tvalid || m_tready) state_next = msw_pkg::S_IDLE;
      default:               state_next = msw_pkg::S_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = m10;
    case (state)
      msw_pkg::S_AX_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(ax);
        mul_b     = MB_W'(ax);
      end
      msw_pkg::S_AY_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(ay);
        mul_b     = MB_W'(ay);
      end
      msw_pkg::S_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(m00);
        mul_b     = MB_W'(m00);
      end
      msw_pkg::S_EP_GO: begin
        mul_start = 1'b1;
        mul_a     = MA_W'(msq);
        mul_b     = MB_W'(epsilon);
      end
      msw_pkg::S_DX_GO: begin
        div_start = 1'b1;
      end
      msw_pkg::S_DY_GO: begin
        div_start = 1'b1;
        div_num   = m01;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == msw_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= msw_pkg::S_IDLE;
      wp             <= '0;
      rd_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
      rec_center_x   <= '0;
      rec_center_y   <= '0;
      rec_centroid_x <= '0;
      rec_centroid_y <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == msw_pkg::S_SWEEP);
      px       <= sx;
      py       <= sy;
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rd_valid) begin
        m00 <= m00 + MASS_W'(mem_rdata);
        m10 <= m10 + MOM_W'(mem_rdata) * MOM_W'(px);
        m01 <= m01 + MOM_W'(mem_rdata) * MOM_W'(py);
      end
      case (state)
        msw_pkg::S_IDLE: begin
          if (s_tvalid && in_kind) begin
            rx     <= rx_start;
            ry     <= ry_start;
            rounds <= '0;
            conv   <= 1'b0;
            empty  <= 1'b0;
          end else if (s_tvalid) begin
            wp <= (FS_W'(wp_inc) >= frame_size) ? '0 : wp_inc[ADDR_W-1:0];
          end
        end
        msw_pkg::S_ROUND_INIT: begin
          row_base <= ADDR_W'(ADDR_W'(fw) * ADDR_W'(ry) + ADDR_W'(rx));
          sx       <= '0;
          sy       <= '0;
          m00      <= '0;
          m10      <= '0;
          m01      <= '0;
        end
        msw_pkg::S_SWEEP: begin
          if (sx == ww - 1'b1) begin
            sx       <= '0;
            sy       <= sy + 1'b1;
            row_base <= ADDR_W'(row_base + ADDR_W'(fw));
          end else begin
            sx <= sx + 1'b1;
          end
        end
        msw_pkg::S_OFFSET_X: begin
          if (m00 == '0) begin
            empty <= 1'b1;
          end
          ax <= (two_m10 >= ww_m00) ? two_m10 - ww_m00 : ww_m00 - two_m10;
        end
        msw_pkg::S_OFFSET_Y: begin
          ay <= (two_m01 >= wh_m00) ? two_m01 - wh_m00 : wh_m00 - two_m01;
        end
        msw_pkg::S_AX_WAIT: if (mul_status.done) sq_sum <= SQ_W'(mul_p);
        msw_pkg::S_AY_WAIT: if (mul_status.done) sq_sum <= sq_sum + SQ_W'(mul_p);
        msw_pkg::S_SQ_WAIT: if (mul_status.done) msq <= MSQ_W'(mul_p);
        msw_pkg::S_EP_WAIT: if (mul_status.done) rhs <= RHS_W'(mul_p);
        msw_pkg::S_COMPARE: if (conv_hit) conv <= 1'b1;
        msw_pkg::S_DX_WAIT: if (div_status.done) gx <= g_round;
        msw_pkg::S_DY_WAIT: if (div_status.done) gy <= g_round;
        msw_pkg::S_MOVE: begin
          rec_center_x   <= CTR_W'(S_W'(rx) + S_W'(cx));
          rec_center_y   <= CTR_W'(S_W'(ry) + S_W'(cy));
          rec_centroid_x <= CTR_W'(S_W'(rx) + S_W'(gx));
          rec_centroid_y <= CTR_W'(S_W'(ry) + S_W'(gy));
          rx             <= rx_move;
          ry             <= ry_move;
          rounds         <= rounds + 1'b1;
        end
        msw_pkg::S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, rounds, rec_centroid_y, rec_centroid_x,
                         rec_center_y, rec_center_x, ROI_W'(ry), ROI_W'(rx)};
            m_tuser  <= {empty, conv};
          end
        end
        default: ;
      endcase
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result flags converged and empty both set");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == msw_pkg::S_FINISH)
    else $error("result beat loaded outside finish");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_status.done |-> (state == msw_pkg::S_AX_WAIT || state == msw_pkg::S_AY_WAIT ||
                         state == msw_pkg::S_SQ_WAIT || state == msw_pkg::S_EP_WAIT))
    else $error("multiplier finished with no one waiting");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == msw_pkg::S_DX_WAIT || state == msw_pkg::S_DY_WAIT))
    else $error("divider finished with no one waiting");

  a_units_free_on_start: assert property (@(posedge clk) disable iff (rst)
    (mul_start |-> !mul_status.busy) and (div_start |-> !div_status.busy))
    else $error("arithmetic unit restarted while busy");

endmodule

>>> hw/rtl/msw_frame_mem.sv
// Frame store: one write port, one read port with registered read data.
// No dependencies.
module msw_frame_mem #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/msw_mul_serial.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on msw_pkg for the unit status struct.
module msw_mul_serial #(
  parameter int A_W = 48,
  parameter int B_W = 33
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   product,
  output msw_pkg::unit_status_t status
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]     mcand;
  logic [A_W+B_W-1:0] acc;
  logic [CNT_W-1:0]   cnt;
  logic               done;
  logic [A_W:0]       upper;

  always_comb begin
    upper = {1'b0, acc[A_W+B_W-1:B_W]} + (acc[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand <= a;
        acc   <= {{A_W{1'b0}}, b};
        cnt   <= CNT_W'(B_W);
      end else if (cnt != '0) begin
        acc <= {upper, acc[B_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign product     = acc;
  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule

>>> hw/rtl/msw_div_serial.sv
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// Depends on msw_pkg for the unit status struct.
module msw_div_serial #(
  parameter int N_W = 32,
  parameter int D_W = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [N_W-1:0]       num,
  input  logic [D_W-1:0]       den,
  output logic [N_W-1:0]       quo,
  output logic [D_W-1:0]       rem,
  output msw_pkg::unit_status_t status
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [D_W-1:0]   den_q;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;

  always_comb begin
    shifted = {rem, quo[N_W-1]};
    trial   = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_q <= den;
        quo   <= num;
        rem   <= '0;
        cnt   <= CNT_W'(N_W);
      end else if (cnt != '0) begin
        if (!trial[D_W]) begin
          rem <= trial[D_W-1:0];
          quo <= {quo[N_W-2:0], 1'b1};
        end else begin
          rem <= shifted[D_W-1:0];
          quo <= {quo[N_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule
